// ===== hdl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types, codes and constants of the fixed-size block pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    // default pool capacity in blocks
    localparam int MAX_BLOCKS_DEF = 256;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int HEAP_W  = 25;
    localparam int BLK_W   = 16;
    localparam int ALIGN_W = 4;
    localparam int UNIT_W  = 17;
    localparam int CMD_W   = 2;
    localparam int STS_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 2;

    // divider widths
    localparam int DVD_W = 32;
    localparam int DVS_W = UNIT_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_FREE = 2'd2;
    localparam logic [STS_W-1:0] STS_NO_BLOCK = 2'd3;

    // register indexes
    localparam logic [REG_W-1:0] REG_HEAP_ADDRESS = 2'd0;
    localparam logic [REG_W-1:0] REG_HEAP_BYTES   = 2'd1;
    localparam logic [REG_W-1:0] REG_BLOCK_BYTES  = 2'd2;
    localparam logic [REG_W-1:0] REG_ALIGN_LOG2   = 2'd3;

    // register reset values
    localparam logic [ADDR_W-1:0]  RST_HEAP_ADDRESS = 32'd0;
    localparam logic [HEAP_W-1:0]  RST_HEAP_BYTES   = 25'd4096;
    localparam logic [BLK_W-1:0]   RST_BLOCK_BYTES  = 16'd64;
    localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2   = 4'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  heap_address;
        logic [HEAP_W-1:0]  heap_bytes;
        logic [BLK_W-1:0]   block_bytes;
        logic [ALIGN_W-1:0] align_log2;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hdl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_div import fbpa_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy,  n_busy;
    logic             r_done,  n_done;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [DVD_W-1:0] r_quot,  n_quot;
    logic [DVS_W-1:0] r_rem,   n_rem;
    logic [DVS_W-1:0] r_dvsr,  n_dvsr;

    logic [DVS_W:0]   w_shift;
    logic             w_ge;
    logic [DVS_W:0]   w_diff;

    assign w_shift = {r_rem, r_quot[DVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvsr});
    assign w_diff  = w_shift - {1'b0, r_dvsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvsr = r_dvsr;
        if (r_busy) begin
            // partial remainder stays below the divisor
            n_rem  = w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            n_quot = {r_quot[DVD_W-2:0], w_ge};
            n_cnt  = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvsr = i_req.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvsr <= n_dvsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/fbpa_regs.sv =====
// ----------------------------------------------------------------------------
// fbpa_regs
// apb configuration registers of the pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_regs import fbpa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg             r_cfg;
    logic             w_wr;
    logic [REG_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heap_address <= RST_HEAP_ADDRESS;
            r_cfg.heap_bytes   <= RST_HEAP_BYTES;
            r_cfg.block_bytes  <= RST_BLOCK_BYTES;
            r_cfg.align_log2   <= RST_ALIGN_LOG2;
        end else if (w_wr) begin
            case (w_idx)
                REG_HEAP_ADDRESS: r_cfg.heap_address <= pwdata;
                REG_HEAP_BYTES:   r_cfg.heap_bytes   <= pwdata[HEAP_W-1:0];
                REG_BLOCK_BYTES:  r_cfg.block_bytes  <= pwdata[BLK_W-1:0];
                REG_ALIGN_LOG2:   r_cfg.align_log2   <= pwdata[ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HEAP_ADDRESS: prdata = r_cfg.heap_address;
            REG_HEAP_BYTES:   prdata = PDATA_W'(r_cfg.heap_bytes);
            REG_BLOCK_BYTES:  prdata = PDATA_W'(r_cfg.block_bytes);
            REG_ALIGN_LOG2:   prdata = PDATA_W'(r_cfg.align_log2);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// fixed-size block pool with a lifo free list held in a separate link ram
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_cmd, i_free_address
//   output    out        o_out_valid / i_out_stall o_block_address, o_status,
//                                                  o_blocks_free
//   config    in         apb psel/penable/pready   paddr, pwdata, prdata
//
// allocate: link ram read, index times unit size, add to pool top
// free: the 32-step shared divider finds the block index and checks the
//   block boundary
// clear: the divider for the block count and then one link ram write per
//   entry to rebuild the ascending chain
// after reset the same rebuild runs with the reset register values, and no
//   input word is taken meanwhile
// a finished result sits in the output register; the next input word is
//   taken while it waits, but that word's result waits for the register
//
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input words
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [CMD_W-1:0]                i_cmd,
    input  wire logic [ADDR_W-1:0]               i_free_address,
    // result words
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [ADDR_W-1:0]               o_block_address,
    output logic      [STS_W-1:0]                o_status,
    output logic      [$clog2(MAX_BLOCKS+1)-1:0] o_blocks_free,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [PADDR_W-1:0]              paddr,
    input  wire logic [PDATA_W-1:0]              pwdata,
    output logic      [PDATA_W-1:0]              prdata,
    output logic                                 pready
);

    // link width holds every index plus the null link
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    // ram address width
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PW = LW + UNIT_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);
    localparam int SW = 4;

    // sequencer states
    localparam logic [SW-1:0] ST_IDLE   = 4'd0;
    localparam logic [SW-1:0] ST_ALLOC  = 4'd1;
    localparam logic [SW-1:0] ST_ALLOC2 = 4'd2;
    localparam logic [SW-1:0] ST_FDIV   = 4'd3;
    localparam logic [SW-1:0] ST_PREP1  = 4'd4;
    localparam logic [SW-1:0] ST_PREP2  = 4'd5;
    localparam logic [SW-1:0] ST_PREP3  = 4'd6;
    localparam logic [SW-1:0] ST_CDIV   = 4'd7;
    localparam logic [SW-1:0] ST_SWEEP  = 4'd8;
    localparam logic [SW-1:0] ST_EMIT   = 4'd9;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // sequencer and pool state
    logic [SW-1:0]     r_state,      n_state;
    logic              r_quiet,      n_quiet;
    logic [LW-1:0]     r_head,       n_head;
    logic [LW-1:0]     r_count,      n_count;
    logic [LW-1:0]     r_total,      n_total;
    logic [ADDR_W-1:0] r_top,        n_top;
    logic              r_top_ovf,    n_top_ovf;
    logic [UNIT_W-1:0] r_unit,       n_unit;
    logic [15:0]       r_pad,        n_pad;
    logic              r_ok,         n_ok;
    logic [IW-1:0]     r_idx,        n_idx;
    logic [PW-1:0]     r_prod,       n_prod;
    logic [ADDR_W-1:0] r_res_addr,   n_res_addr;
    logic [STS_W-1:0]  r_res_status, n_res_status;

    // output register
    logic              r_out_valid,  n_out_valid;
    logic [ADDR_W-1:0] r_out_addr,   n_out_addr;
    logic [STS_W-1:0]  r_out_status, n_out_status;
    logic [LW-1:0]     r_out_free,   n_out_free;

    // link ram ports
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic [LW-1:0] w_rdata;

    // datapath helpers
    logic              w_accept;
    logic [15:0]       w_align_m1;
    logic [ADDR_W:0]   w_top33;
    logic [UNIT_W-1:0] w_unit;
    logic [ADDR_W:0]   w_pad33;
    logic [HEAP_W-1:0] w_room;
    logic [ADDR_W:0]   w_space;
    logic [HEAP_W-1:0] w_room_c;
    logic [ADDR_W-1:0] w_off;
    logic              w_free_ok;
    logic [LW-1:0]     w_chain;
    logic [PW-1:0]     w_prod;

    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fbpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    fbpa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // rebuild step one: round heap address and block size up to the alignment
    assign w_align_m1 = (16'd1 << w_cfg.align_log2) - 16'd1;
    assign w_top33    = ({1'b0, w_cfg.heap_address} + (ADDR_W+1)'(w_align_m1))
                        & ~((ADDR_W+1)'(w_align_m1));
    assign w_unit     = (UNIT_W'(w_cfg.block_bytes) + UNIT_W'(w_align_m1))
                        & ~(UNIT_W'(w_align_m1));

    // rebuild step two: alignment pad in front of the pool
    assign w_pad33 = {r_top_ovf, r_top} - {1'b0, w_cfg.heap_address};

    // rebuild step three: room left, clipped to the end of the address space
    assign w_room   = w_cfg.heap_bytes - HEAP_W'(r_pad);
    assign w_space  = {1'b1, {ADDR_W{1'b0}}} - {1'b0, r_top};
    assign w_room_c = ((ADDR_W+1)'(w_room) > w_space) ? w_space[HEAP_W-1:0] : w_room;

    // free precheck; boundary and range come from the divider
    assign w_off     = i_free_address - r_top;
    assign w_free_ok = (r_total != '0) && (r_count < r_total) && (i_free_address >= r_top);

    // ascending chain value of the entry being swept
    assign w_chain = ((LW'(r_idx) + LW'(1)) < r_total) ? (LW'(r_idx) + LW'(1)) : NULL_LINK;

    assign w_prod = {{UNIT_W{1'b0}}, r_head} * {{LW{1'b0}}, r_unit};

    always_comb begin
        n_state      = r_state;
        n_quiet      = r_quiet;
        n_head       = r_head;
        n_count      = r_count;
        n_total      = r_total;
        n_top        = r_top;
        n_top_ovf    = r_top_ovf;
        n_unit       = r_unit;
        n_pad        = r_pad;
        n_ok         = r_ok;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;

        // result register drains when taken
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_off;
        w_div_req.divisor  = r_unit;

        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_chain;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_addr   = '0;
                    n_res_status = STS_OK;
                    case (i_cmd)
                        CMD_ALLOC: begin
                            if (r_count == '0 || r_head >= NULL_LINK) begin
                                n_res_status = STS_EMPTY;
                                n_state      = ST_EMIT;
                            end else begin
                                n_state = ST_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            if (i_free_address == '0) begin
                                // zero address frees nothing
                                n_state = ST_EMIT;
                            end else if (w_free_ok) begin
                                w_div_req.start = 1'b1;
                                n_state         = ST_FDIV;
                            end else begin
                                n_res_status = STS_BAD_FREE;
                                n_state      = ST_EMIT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_state = ST_PREP1;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                // link ram read of the head is under way
                n_prod  = w_prod;
                n_state = ST_ALLOC2;
            end
            ST_ALLOC2: begin
                n_res_addr = r_top + ADDR_W'(r_prod);
                n_head     = w_rdata;
                n_count    = r_count - LW'(1);
                n_state    = ST_EMIT;
            end
            ST_FDIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.rem == '0 && w_div_rsp.quot < DVD_W'(r_total)) begin
                        // push the block in front of the old head
                        w_we    = 1'b1;
                        w_waddr = w_div_rsp.quot[IW-1:0];
                        w_wdata = r_head;
                        n_head  = w_div_rsp.quot[LW-1:0];
                        n_count = r_count + LW'(1);
                    end else begin
                        n_res_status = STS_BAD_FREE;
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_PREP1: begin
                n_top     = w_top33[ADDR_W-1:0];
                n_top_ovf = w_top33[ADDR_W];
                n_unit    = w_unit;
                n_state   = ST_PREP2;
            end
            ST_PREP2: begin
                n_pad   = w_pad33[15:0];
                n_ok    = (w_pad33 < (ADDR_W+1)'(w_cfg.heap_bytes)) && (r_unit != '0)
                          && !r_top_ovf;
                n_state = ST_PREP3;
            end
            ST_PREP3: begin
                if (r_ok) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = DVD_W'(w_room_c);
                    n_state            = ST_CDIV;
                end else begin
                    // heap holds no block
                    n_total = '0;
                    n_count = '0;
                    n_head  = NULL_LINK;
                    n_idx   = '0;
                    n_state = ST_SWEEP;
                end
            end
            ST_CDIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quot > DVD_W'(MAX_BLOCKS)) begin
                        n_total = NULL_LINK;
                        n_count = NULL_LINK;
                    end else begin
                        n_total = w_div_rsp.quot[LW-1:0];
                        n_count = w_div_rsp.quot[LW-1:0];
                    end
                    n_head  = (w_div_rsp.quot == '0) ? NULL_LINK : '0;
                    n_idx   = '0;
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                w_we  = 1'b1;
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(MAX_BLOCKS - 1)) begin
                    n_res_addr   = '0;
                    n_res_status = (r_total == '0) ? STS_NO_BLOCK : STS_OK;
                    if (r_quiet) begin
                        // rebuild after reset gives no result
                        n_quiet = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_out_free   = r_count;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PREP1;
            r_quiet     <= 1'b1;
            r_out_valid <= 1'b0;
            r_head      <= NULL_LINK;
            r_count     <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_quiet     <= n_quiet;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_count     <= n_count;
            r_total     <= n_total;
        end
        r_top        <= n_top;
        r_top_ovf    <= n_top_ovf;
        r_unit       <= n_unit;
        r_pad        <= n_pad;
        r_ok         <= n_ok;
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_blocks_free   = r_out_free;

endmodule

`default_nettype wire

// ===== hdl/fbpa_chk.sv =====
// ----------------------------------------------------------------------------
// fbpa_chk
// port-level checks of the pool allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_chk import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [ADDR_W-1:0]               o_block_address,
    input wire logic [STS_W-1:0]                o_status,
    input wire logic [$clog2(MAX_BLOCKS+1)-1:0] o_blocks_free
);

    localparam int LW = $clog2(MAX_BLOCKS + 1);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_block_address)
            && $stable(o_status) && $stable(o_blocks_free))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // only a successful allocate hands out an address
    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_block_address == '0)
        else $error("address given with a failing status");

    // free count never exceeds the pool capacity
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_blocks_free <= LW'(MAX_BLOCKS))
        else $error("free count beyond pool capacity");

endmodule

bind fixed_block_pool_allocator fbpa_chk #(.MAX_BLOCKS(MAX_BLOCKS)) u_fbpa_chk (.*);

`default_nettype wire
